@@ hdl/twlh_pkg.sv @@
// Package for the task wait-latency histogram.
// Holds field widths, constants and the controller/datapath command types.
// No dependencies.
package twlh_pkg;

  // Field widths
  localparam int ID_W      = 10;
  localparam int TIME_W    = 64;
  localparam int PREFIX_W  = 32;
  localparam int THR_W     = 40;
  localparam int BKT_OUT_W = 5;

  // Latency is compared against 1000 << i, which fits in 74 bits for i up to 63
  localparam int LAT_EXT_W = 74;

  // Default sizes
  localparam int DEF_TASK_SLOTS = 1024;
  localparam int DEF_BUCKETS    = 20;

  // Constants
  localparam logic [TIME_W-1:0] NS_PER_US    = 64'd1000;
  localparam logic [THR_W-1:0]  THRESH_RESET = 40'd10000000;

  // Accepted task name prefixes, byte 0 in bits 7:0
  localparam logic [31:0] NAME_PFX_A = 32'h756d6571;  // four-byte prefix
  localparam logic [23:0] NAME_PFX_B = 24'h6d766b;    // three-byte prefix

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;      // clearing pass: zero one stamp and/or one bucket entry
    logic accept;     // capture input word, issue stamp read
    logic stamp_chk;  // stamp data valid: latency, compares, hit
    logic bucket_rd;  // encode bucket, issue histogram read
    logic commit;     // write back tables, load result register
  } twlh_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;  // last entry of the clearing pass
  } twlh_status_t;

endpackage

@@ hdl/twlh_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module twlh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/twlh_ctrl.sv @@
// Controller for the task wait-latency histogram: sequencing state machine
// and the output valid flag. Depends on twlh_pkg.
module twlh_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  twlh_pkg::twlh_status_t status,
  output twlh_pkg::twlh_cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_STAMP  = 3'd2;
  localparam logic [2:0] S_BUCKET = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  // Result register can take a new word when empty or being drained
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.clear     = (state == S_CLEAR);
    cmd.accept    = (state == S_IDLE) && in_valid;
    cmd.stamp_chk = (state == S_STAMP);
    cmd.bucket_rd = (state == S_BUCKET);
    cmd.commit    = (state == S_COMMIT) && out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (status.clear_last) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_STAMP;
      S_STAMP:  state_next = S_BUCKET;
      S_BUCKET: state_next = S_COMMIT;
      S_COMMIT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/twlh_dp.sv @@
// Datapath for the task wait-latency histogram: stamp table, histogram,
// latency and bucket logic, threshold register, result register.
// Depends on twlh_pkg and twlh_ram.
module twlh_dp #(
  parameter int TASK_SLOTS = twlh_pkg::DEF_TASK_SLOTS,
  parameter int BUCKETS    = twlh_pkg::DEF_BUCKETS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  twlh_pkg::twlh_cmd_t              cmd,
  output twlh_pkg::twlh_status_t           status,
  input  logic                             cfg_wr_en,
  input  logic [twlh_pkg::THR_W-1:0]       cfg_wr_data,
  input  logic                             func,
  input  logic [twlh_pkg::ID_W-1:0]        task_id,
  input  logic [twlh_pkg::TIME_W-1:0]      now_ns,
  input  logic [twlh_pkg::PREFIX_W-1:0]    name_prefix,
  output logic                             recorded,
  output logic [twlh_pkg::BKT_OUT_W-1:0]   bucket,
  output logic [twlh_pkg::TIME_W-1:0]      bucket_count,
  output logic [twlh_pkg::TIME_W-1:0]      wait_ns,
  output logic [twlh_pkg::TIME_W-1:0]      start_ns,
  output logic                             over_threshold
);

  localparam int IDX_W = $clog2(TASK_SLOTS);
  localparam int BK_W  = $clog2(BUCKETS);
  localparam int CLR_N = (TASK_SLOTS > BUCKETS) ? TASK_SLOTS : BUCKETS;
  localparam int CLR_W = $clog2(CLR_N);
  localparam int TW    = twlh_pkg::TIME_W;
  localparam int EXT_W = twlh_pkg::LAT_EXT_W;

  // Threshold register
  logic [twlh_pkg::THR_W-1:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= twlh_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  // Clearing pass counter
  logic [CLR_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign status.clear_last = (clr_cnt == CLR_W'(CLR_N - 1));

  // Input decode
  logic [IDX_W+twlh_pkg::ID_W-1:0] id_ext;
  logic [IDX_W-1:0]                idx;
  logic                            in_range;
  logic                            name_ok;

  assign id_ext   = {{IDX_W{1'b0}}, task_id};
  assign idx      = id_ext[IDX_W-1:0];
  assign in_range = 32'(task_id) < 32'(TASK_SLOTS);
  assign name_ok  = (name_prefix == twlh_pkg::NAME_PFX_A) ||
                    (name_prefix[23:0] == twlh_pkg::NAME_PFX_B);

  // Captured input word
  logic             func_q;
  logic             in_range_q;
  logic             name_ok_q;
  logic [IDX_W-1:0] idx_q;
  logic [TW-1:0]    now_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q     <= func;
      in_range_q <= in_range;
      name_ok_q  <= name_ok;
      idx_q      <= idx;
      now_q      <= now_ns;
    end
  end

  // Stamp table
  logic             st_we;
  logic [IDX_W-1:0] st_waddr;
  logic [TW-1:0]    st_wdata;
  logic [TW-1:0]    st_rdata;
  logic             hit_q;

  always_comb begin
    if (cmd.clear) begin
      st_we    = {1'b0, clr_cnt} < (CLR_W+1)'(TASK_SLOTS);
      st_waddr = clr_cnt[IDX_W-1:0];
      st_wdata = '0;
    end else begin
      // enqueue stores the time, a counted switch clears the stamp
      st_we    = cmd.commit && in_range_q && (!func_q || hit_q);
      st_waddr = idx_q;
      st_wdata = func_q ? '0 : now_q;
    end
  end

  twlh_ram #(.WIDTH(TW), .DEPTH(TASK_SLOTS)) u_stamps (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (cmd.accept),
    .raddr (idx),
    .rdata (st_rdata)
  );

  // Latency, threshold and bucket boundary compares
  logic [TW-1:0]      lat;
  logic [EXT_W-1:0]   lat_ext;
  logic [BUCKETS-2:0] ge;
  logic               over_q;
  logic [TW-1:0]      lat_q;
  logic [TW-1:0]      start_q;
  logic [BUCKETS-2:0] ge_q;

  assign lat     = now_q - st_rdata;
  assign lat_ext = {{(EXT_W-TW){1'b0}}, lat};

  // us < 2^i is the same as ns < 1000 * 2^i
  always_comb begin
    for (int i = 0; i < BUCKETS - 1; i++) begin
      ge[i] = lat_ext >= (EXT_W'(twlh_pkg::NS_PER_US) << i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stamp_chk) begin
      hit_q   <= func_q && in_range_q && name_ok_q && (st_rdata != '0);
      over_q  <= lat > {{(TW-twlh_pkg::THR_W){1'b0}}, thr};
      lat_q   <= lat;
      start_q <= st_rdata;
      ge_q    <= ge;
    end
  end

  // Bucket encode: boundaries are monotone, so the highest passed one wins
  logic [BK_W-1:0] bkt_enc;
  logic [BK_W-1:0] bucket_q;

  always_comb begin
    bkt_enc = '0;
    for (int i = 0; i < BUCKETS - 1; i++) begin
      if (ge_q[i]) begin
        bkt_enc = BK_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bucket_rd) begin
      bucket_q <= bkt_enc;
    end
  end

  // Histogram
  logic            h_we;
  logic [BK_W-1:0] h_waddr;
  logic [TW-1:0]   h_wdata;
  logic [TW-1:0]   h_rdata;
  logic [TW-1:0]   cnt_inc;

  assign cnt_inc = h_rdata + 1'b1;

  always_comb begin
    if (cmd.clear) begin
      h_we    = {1'b0, clr_cnt} < (CLR_W+1)'(BUCKETS);
      h_waddr = clr_cnt[BK_W-1:0];
      h_wdata = '0;
    end else begin
      h_we    = cmd.commit && hit_q;
      h_waddr = bucket_q;
      h_wdata = cnt_inc;
    end
  end

  twlh_ram #(.WIDTH(TW), .DEPTH(BUCKETS)) u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (cmd.bucket_rd),
    .raddr (bkt_enc),
    .rdata (h_rdata)
  );

  // Result register; fields read zero when nothing was counted
  logic [BK_W+twlh_pkg::BKT_OUT_W-1:0] bkt_ext;

  assign bkt_ext = {{twlh_pkg::BKT_OUT_W{1'b0}}, bucket_q};

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      recorded       <= hit_q;
      bucket         <= hit_q ? bkt_ext[twlh_pkg::BKT_OUT_W-1:0] : '0;
      bucket_count   <= hit_q ? cnt_inc : '0;
      wait_ns        <= hit_q ? lat_q : '0;
      start_ns       <= hit_q ? start_q : '0;
      over_threshold <= hit_q && over_q;
    end
  end

endmodule

@@ hdl/task_wait_latency_histogram_top.sv @@
// Top level of the task wait-latency histogram.
// Depends on twlh_pkg, twlh_ctrl and twlh_dp.
//
// Measures enqueue-to-switch wait time per task and counts it in a log2
// microsecond histogram. After reset the stamp table and histogram are
// zeroed by a clearing pass over max(TASK_SLOTS, BUCKETS) entries (1024 by
// default), during which in_stall is high; threshold writes are taken at any
// time. Every input word gives exactly one result word. An accepted word goes
// through the stamp, bucket and commit states before it reaches the result
// register, and the next word is accepted only after it commits. The two
// read-modify-write passes, one on the stamp table and one on the histogram
// counter, each go through a registered RAM read. A finished result may wait
// in the output register while the next word is accepted; a word commits only
// once that register is free.
module task_wait_latency_histogram_top #(
  parameter int TASK_SLOTS = twlh_pkg::DEF_TASK_SLOTS,
  parameter int BUCKETS    = twlh_pkg::DEF_BUCKETS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [twlh_pkg::THR_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [twlh_pkg::ID_W-1:0]      task_id,
  input  logic [twlh_pkg::TIME_W-1:0]    now_ns,
  input  logic [twlh_pkg::PREFIX_W-1:0]  name_prefix,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           recorded,
  output logic [twlh_pkg::BKT_OUT_W-1:0] bucket,
  output logic [twlh_pkg::TIME_W-1:0]    bucket_count,
  output logic [twlh_pkg::TIME_W-1:0]    wait_ns,
  output logic [twlh_pkg::TIME_W-1:0]    start_ns,
  output logic                           over_threshold
);

  twlh_pkg::twlh_cmd_t    cmd;
  twlh_pkg::twlh_status_t status;

  twlh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  twlh_dp #(
    .TASK_SLOTS (TASK_SLOTS),
    .BUCKETS    (BUCKETS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .func           (func),
    .task_id        (task_id),
    .now_ns         (now_ns),
    .name_prefix    (name_prefix),
    .recorded       (recorded),
    .bucket         (bucket),
    .bucket_count   (bucket_count),
    .wait_ns        (wait_ns),
    .start_ns       (start_ns),
    .over_threshold (over_threshold)
  );

endmodule

@@ hdl/twlh_chk.sv @@
// Port-level checker for the task wait-latency histogram, bound to the top.
// Depends on twlh_pkg and task_wait_latency_histogram_top.
module twlh_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           recorded,
  input logic [twlh_pkg::BKT_OUT_W-1:0] bucket,
  input logic [twlh_pkg::TIME_W-1:0]    bucket_count,
  input logic [twlh_pkg::TIME_W-1:0]    wait_ns,
  input logic [twlh_pkg::TIME_W-1:0]    start_ns,
  input logic                           over_threshold
);

  // Uncounted words carry all-zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !recorded |-> bucket == '0 && bucket_count == '0 &&
      wait_ns == '0 && start_ns == '0 && !over_threshold)
    else $error("uncounted result word has nonzero fields");

  // A counted word consumed a real stamp
  a_stamp_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && recorded |-> start_ns != '0)
    else $error("counted result word with zero start stamp");

  // Over-threshold latency is never zero
  a_over_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && over_threshold |-> wait_ns != '0)
    else $error("over_threshold set with zero latency");

  // Words are processed one at a time: no acceptance on the next edge
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive edges");

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(recorded) && $stable(bucket) &&
      $stable(bucket_count) && $stable(wait_ns) && $stable(start_ns) &&
      $stable(over_threshold))
    else $error("stalled result word changed");

endmodule

bind task_wait_latency_histogram_top twlh_chk u_twlh_chk (.*);

@@ verif/task_wait_latency_histogram_top_test.sv @@
// Self-checking testbench for task_wait_latency_histogram_top.
// Depends on twlh_pkg and the block's RTL. Predicts every result word from
// its own copy of the stamp table, histogram and report threshold.
module task_wait_latency_histogram_top_test;

  localparam int ID_W      = twlh_pkg::ID_W;
  localparam int TIME_W    = twlh_pkg::TIME_W;
  localparam int PREFIX_W  = twlh_pkg::PREFIX_W;
  localparam int THR_W     = twlh_pkg::THR_W;
  localparam int BKT_OUT_W = twlh_pkg::BKT_OUT_W;
  localparam logic [TIME_W-1:0] NS_PER_US    = twlh_pkg::NS_PER_US;
  localparam logic [THR_W-1:0]  THRESH_RESET = twlh_pkg::THRESH_RESET;
  localparam logic [31:0]       NAME_PFX_A   = twlh_pkg::NAME_PFX_A;
  localparam logic [23:0]       NAME_PFX_B   = twlh_pkg::NAME_PFX_B;

  localparam int SLOTS        = twlh_pkg::DEF_TASK_SLOTS;
  localparam int NBKT         = twlh_pkg::DEF_BUCKETS;
  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_SWITCH  = 1'b1;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic                func;
    logic [ID_W-1:0]     task_id;
    logic [TIME_W-1:0]   now_ns;
    logic [PREFIX_W-1:0] name_prefix;
  } sched_word_t;

  typedef struct packed {
    logic                 recorded;
    logic [BKT_OUT_W-1:0] bucket;
    logic [TIME_W-1:0]    bucket_count;
    logic [TIME_W-1:0]    wait_ns;
    logic [TIME_W-1:0]    start_ns;
    logic                 over_threshold;
  } latency_record_t;

  // DUT signals, all inputs known from time zero
  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  cfg_wr_en   = 1'b0;
  logic [THR_W-1:0]      cfg_wr_data = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  func        = 1'b0;
  logic [ID_W-1:0]       task_id     = '0;
  logic [TIME_W-1:0]     now_ns      = '0;
  logic [PREFIX_W-1:0]   name_prefix = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic                  recorded;
  logic [BKT_OUT_W-1:0]  bucket;
  logic [TIME_W-1:0]     bucket_count;
  logic [TIME_W-1:0]     wait_ns;
  logic [TIME_W-1:0]     start_ns;
  logic                  over_threshold;

  // Predictor state
  logic [TIME_W-1:0] stamp_tbl [SLOTS];
  logic [TIME_W-1:0] hist_tbl [NBKT];
  logic [THR_W-1:0]  thr_ns;
  latency_record_t   record_q [$];
  logic [ID_W-1:0]   armed_q [$];
  idle_mode_t        idle_mode = IDLE_NONE;
  int                mismatches = 0;

  task_wait_latency_histogram_top uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop on a hang
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Expected result of one accepted word; updates the predictor state
  function automatic latency_record_t account_wait(sched_word_t w);
    latency_record_t r;
    logic [TIME_W-1:0] us;
    logic name_ok;
    int b;
    r = '0;
    name_ok = (w.name_prefix == NAME_PFX_A) || (w.name_prefix[23:0] == NAME_PFX_B);
    if (w.func == FUNC_ENQUEUE) begin
      stamp_tbl[w.task_id] = w.now_ns;
    end else if (name_ok && stamp_tbl[w.task_id] != '0) begin
      r.recorded = 1'b1;
      r.start_ns = stamp_tbl[w.task_id];
      r.wait_ns  = w.now_ns - r.start_ns;
      us = r.wait_ns / NS_PER_US;
      // smallest i with us < 2^i, overflow lands in the last bucket
      b = NBKT - 1;
      for (int i = NBKT - 1; i >= 0; i--)
        if (us < (64'd1 << i)) b = i;
      hist_tbl[b] = hist_tbl[b] + 64'd1;
      r.bucket         = b[BKT_OUT_W-1:0];
      r.bucket_count   = hist_tbl[b];
      r.over_threshold = r.wait_ns > TIME_W'(thr_ns);
      stamp_tbl[w.task_id] = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] result mismatch on %s: expected %0h, got %0h", $time, field, want, got);
  endtask

  // Result checker: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    latency_record_t want;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (record_q.size() == 0) begin
        report_mismatch("word with nothing expected", '0, '1);
      end else begin
        want = record_q.pop_front();
        if (recorded !== want.recorded)
          report_mismatch("recorded", 64'(want.recorded), 64'(recorded));
        if (bucket !== want.bucket)
          report_mismatch("bucket", 64'(want.bucket), 64'(bucket));
        if (bucket_count !== want.bucket_count)
          report_mismatch("bucket_count", want.bucket_count, bucket_count);
        if (wait_ns !== want.wait_ns)
          report_mismatch("wait_ns", want.wait_ns, wait_ns);
        if (start_ns !== want.start_ns)
          report_mismatch("start_ns", want.start_ns, start_ns);
        if (over_threshold !== want.over_threshold)
          report_mismatch("over_threshold", 64'(want.over_threshold), 64'(over_threshold));
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    int pct;
    pct = (idle_mode == IDLE_RECEIVER) ? 88 : (idle_mode == IDLE_BOTH) ? 9 : 0;
    out_stall <= ($urandom_range(0, 99) < pct);
  end

  // Offer one word after a random gap, hold it until accepted
  task automatic send_word(input sched_word_t w);
    int pct;
    int gap;
    pct = (idle_mode == IDLE_SENDER) ? 88 : (idle_mode == IDLE_BOTH) ? 9 : 0;
    gap = 0;
    while ($urandom_range(0, 99) < pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    func        <= w.func;
    task_id     <= w.task_id;
    now_ns      <= w.now_ns;
    name_prefix <= w.name_prefix;
    do @(posedge clk); while (in_stall !== 1'b0);
    record_q.push_back(account_wait(w));
  endtask

  task automatic send_fields(input logic f, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] t, input logic [PREFIX_W-1:0] p);
    sched_word_t w;
    w.func        = f;
    w.task_id     = id;
    w.now_ns      = t;
    w.name_prefix = p;
    send_word(w);
  endtask

  // Stop sending and wait until every expected word has come back
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (record_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_report_threshold(input logic [THR_W-1:0] value);
    wait_for_drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    thr_ns = value;
  endtask

  // Random word: mostly enqueue/switch pairs, some noise and broken pairs
  function automatic sched_word_t next_random_word();
    sched_word_t w;
    logic [TIME_W-1:0] lat;
    logic [7:0] b3;
    int pick;
    int idx;
    int k;
    w.func        = 1'($urandom_range(0, 1));
    w.task_id     = ID_W'($urandom_range(0, SLOTS - 1));
    w.now_ns      = rand64();
    w.name_prefix = $urandom;
    b3            = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 20) return w;
    if (pick < 55 || armed_q.size() == 0) begin
      w.func = FUNC_ENQUEUE;
      if ($urandom_range(0, 49) == 0) w.now_ns = '0;  // zero stamp arms nothing
      else armed_q.push_back(w.task_id);
      return w;
    end
    // switch in an armed task, latency spread over all buckets
    idx = $urandom_range(0, armed_q.size() - 1);
    w.task_id = armed_q[idx];
    armed_q.delete(idx);
    w.func = FUNC_SWITCH;
    k = ($urandom_range(0, 9) == 0) ? 63 : $urandom_range(0, 34);
    lat = rand64() & ((64'd1 << (k + 1)) - 64'd1);
    w.now_ns = stamp_tbl[w.task_id] + lat;
    case ($urandom_range(0, 9))
      0:          w.name_prefix = NAME_PFX_A ^ (32'd1 << $urandom_range(0, 31));
      1, 2, 3, 4: w.name_prefix = NAME_PFX_A;
      default:    w.name_prefix = {b3, NAME_PFX_B};
    endcase
    return w;
  endfunction

  // Prefix filter: both prefixes, near misses, all-zero and all-one names
  task automatic test_name_filter();
    send_fields(FUNC_ENQUEUE, 10'd1023, 64'd5000, '0);
    send_fields(FUNC_SWITCH, 10'd1023, 64'd5500, {8'h76, NAME_PFX_A[23:0]});  // "qemv"
    send_fields(FUNC_SWITCH, 10'd1023, 64'd5500, {16'h006e, NAME_PFX_B[15:0]});  // "kvn"
    send_fields(FUNC_SWITCH, 10'd1023, 64'd5500, '1);
    send_fields(FUNC_SWITCH, 10'd1023, 64'd5500, '0);
    send_fields(FUNC_SWITCH, 10'd1023, 64'd6000, {8'ha5, NAME_PFX_B});
    // stamp consumed, nothing pending now
    send_fields(FUNC_SWITCH, 10'd1023, 64'd7000, NAME_PFX_A);
  endtask

  // Zero stamp reads as none pending; a second enqueue overwrites the first
  task automatic test_stamp_rules();
    send_fields(FUNC_ENQUEUE, 10'd7, 64'd0, '0);
    send_fields(FUNC_SWITCH, 10'd7, 64'd100, NAME_PFX_A);
    send_fields(FUNC_ENQUEUE, 10'd3, 64'd100, '1);
    send_fields(FUNC_ENQUEUE, 10'd3, 64'd200, '0);
    send_fields(FUNC_SWITCH, 10'd3, 64'd1199, NAME_PFX_A);
  endtask

  // Bucket boundaries, overflow bucket, zero latency, wrapped latency
  task automatic test_bucket_edges();
    send_fields(FUNC_ENQUEUE, 10'd5, 64'd7, '0);
    send_fields(FUNC_SWITCH, 10'd5, 64'd7 + 64'd262143999, NAME_PFX_A);
    send_fields(FUNC_ENQUEUE, 10'd6, 64'd1000000, '0);
    send_fields(FUNC_SWITCH, 10'd6, 64'd1000000 + 64'd262144000, NAME_PFX_A);
    send_fields(FUNC_ENQUEUE, 10'd9, '1, '0);
    send_fields(FUNC_SWITCH, 10'd9, 64'hFFFF_FFFF_FFFF_FFFE, {8'h00, NAME_PFX_B});
    send_fields(FUNC_ENQUEUE, 10'd0, 64'd1, '0);
    send_fields(FUNC_SWITCH, 10'd0, 64'd1, {8'hff, NAME_PFX_B});
  endtask

  // Latency equal to the threshold is not flagged, one more is
  task automatic test_threshold_edge();
    send_fields(FUNC_ENQUEUE, 10'd4, 64'd1, '0);
    send_fields(FUNC_SWITCH, 10'd4, 64'd1 + TIME_W'(THRESH_RESET), NAME_PFX_A);
    send_fields(FUNC_ENQUEUE, 10'd4, 64'd1, '0);
    send_fields(FUNC_SWITCH, 10'd4, 64'd2 + TIME_W'(THRESH_RESET), NAME_PFX_A);
  endtask

  task automatic run_phase(input idle_mode_t mode, input int words);
    idle_mode = mode;
    for (int n = 0; n < words; n++) begin
      send_word(next_random_word());
      if ($urandom_range(0, 99) == 0) wait_for_drain();
    end
  endtask

  // Random traffic over all idle patterns and several threshold settings
  task automatic test_random_phases();
    logic [63:0] r;
    run_phase(IDLE_NONE, 200);
    set_report_threshold('0);
    run_phase(IDLE_SENDER, 150);
    set_report_threshold('1);
    run_phase(IDLE_RECEIVER, 150);
    r = rand64();
    set_report_threshold(r[THR_W-1:0]);
    run_phase(IDLE_BOTH, 250);
    set_report_threshold(THR_W'($urandom_range(0, 500000000)));
    run_phase(IDLE_NONE, 250);
  endtask

  initial begin
    foreach (stamp_tbl[i]) stamp_tbl[i] = '0;
    foreach (hist_tbl[i]) hist_tbl[i] = '0;
    thr_ns = THRESH_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_name_filter();
    test_stamp_rules();
    test_bucket_edges();
    test_threshold_edge();
    test_random_phases();

    wait_for_drain();
    idle_mode = IDLE_NONE;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
